// File: rtl/black_bar_window_stabilizer_unit_macros.svh
// assertion macros shared by the checker file
`ifndef BLACK_BAR_WINDOW_STABILIZER_UNIT_MACROS_SVH
`define BLACK_BAR_WINDOW_STABILIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BBWS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BBWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bbws_pkg.sv
// shared constants and payload types of the black bar window stabilizer
`timescale 1ns / 1ps
`default_nettype none

package bbws_pkg;

    localparam int BBWS_HISTORY_DEPTH  = 4;
    localparam int BBWS_RAW_COORD_BITS = 12;

    localparam int SIZE_W     = 13;
    localparam int RATE_W     = 10;
    localparam int THR_W      = 13;
    localparam int OUT_X_W    = 13;
    localparam int OUT_Y_W    = 12;
    localparam int CNT_OUT_W  = 3;
    localparam int MASK_OUT_W = 4;
    localparam int SKIP_W     = 3;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

    // skip codes, first zero field found wins
    localparam logic [SKIP_W-1:0] SKIP_NONE      = 3'd0;
    localparam logic [SKIP_W-1:0] SKIP_FRAME_W   = 3'd1;
    localparam logic [SKIP_W-1:0] SKIP_FRAME_H   = 3'd2;
    localparam logic [SKIP_W-1:0] SKIP_RATE      = 3'd3;
    localparam logic [SKIP_W-1:0] SKIP_INPUT_W   = 3'd4;
    localparam logic [SKIP_W-1:0] SKIP_INPUT_H   = 3'd5;

    // different two frames ago, same last frame, same now
    localparam logic [2:0] SAME_STABLE  = 3'b011;
    localparam int         MATCH_STABLE = 3;

    typedef struct packed {
        logic                  was_clamped;
        logic [MASK_OUT_W-1:0] match_mask;
        logic [CNT_OUT_W-1:0]  match_count;
        logic [SIZE_W-1:0]     active_h;
        logic [SIZE_W-1:0]     active_w;
        logic [OUT_Y_W-1:0]    active_y;
        logic [OUT_X_W-1:0]    active_x;
    } result_t;

    typedef struct packed {
        logic [SKIP_W-1:0] skip_code;
        logic              report_change;
    } result_user_t;

    localparam int RESULT_W  = $bits(result_t);
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;
    localparam int M_TUSER_W = $bits(result_user_t);

endpackage

`default_nettype wire

// File: rtl/black_bar_window_stabilizer_unit.sv
// black bar window stabilizer: top level with state, history match and stream stages
// accepted word: input register, then result register once the output is free
// throughput: one word per cycle unless stalled by m_axis_tready; input register,
// single logic pass, result register; the history compare over all entries runs in
// parallel within that pass; reset (aresetn low, synchronous): both stages empty,
// threshold 5, edges and rectangles all ones, same/different history zero
`timescale 1ns / 1ps
`default_nettype none

module black_bar_window_stabilizer_unit import bbws_pkg::*; #(
    parameter  int HISTORY_DEPTH  = BBWS_HISTORY_DEPTH,
    parameter  int RAW_COORD_BITS = BBWS_RAW_COORD_BITS,
    localparam int S_FIELDS_W     = 4 * RAW_COORD_BITS + 4 * SIZE_W + RATE_W,
    localparam int S_TDATA_W      = ((S_FIELDS_W + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [THR_W-1:0]     cfg_wdata,     // jitter_threshold
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // raw_x_start, raw_y_start, raw_x_end, raw_y_end, frame_width, frame_height,
    // frame_rate, input_width, input_height
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // active_x, active_y, active_w, active_h, match_count, match_mask, was_clamped
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // report_change, skip_code
    output logic [M_TUSER_W-1:0]      m_axis_tuser
);

    localparam int R     = RAW_COORD_BITS;
    localparam int RW    = (R + 1) + R + 2 * SIZE_W;
    localparam int CNTW  = $clog2(HISTORY_DEPTH + 2);
    localparam int CXW   = (CNTW > CNT_OUT_W) ? CNTW : CNT_OUT_W;
    localparam int MXW   = (HISTORY_DEPTH > MASK_OUT_W) ? HISTORY_DEPTH : MASK_OUT_W;
    localparam int SZ2   = 2 * SIZE_W;

    // input stage
    logic                 in_valid_reg, in_valid_next;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic                 advance;
    logic                 s_accept;

    // state
    logic [THR_W-1:0]   thr_reg;
    logic [R-1:0]       prev_l_reg, prev_l_next;
    logic [R-1:0]       prev_r_reg, prev_r_next;
    logic [R-1:0]       held_l_reg, held_l_next;
    logic [R-1:0]       held_r_reg, held_r_next;
    logic [SZ2-1:0]     prev_size_reg, prev_size_next;
    logic [RW-1:0]      prev_rect_reg, prev_rect_next;
    logic [RW-1:0]      hist_reg [HISTORY_DEPTH];
    logic [RW-1:0]      reported_reg, reported_next;
    logic [2:0]         same_hist_reg, same_hist_next;

    // output stage
    logic               m_valid_reg, m_valid_next;
    result_t            res_reg, res_next;
    result_user_t       user_reg, user_next;

    // unpacked input fields
    logic [R-1:0]       f_x0, f_y0, f_x1, f_y1;
    logic [SIZE_W-1:0]  f_fw, f_fh, f_iw, f_ih;
    logic [RATE_W-1:0]  f_rate;

    logic [R-1:0]       sel_l, sel_r;
    logic [R:0]         act_x;
    logic [R-1:0]       act_y;
    logic [SIZE_W-1:0]  act_w, act_h;
    logic               clamped;
    logic [RW-1:0]      act_rect;

    logic [SKIP_W-1:0]        skip;
    logic [HISTORY_DEPTH-1:0] match;
    logic [MXW-1:0]           match_ext;
    logic [CXW-1:0]           cnt_ext;
    logic                     same;
    logic                     stable;
    logic                     report;

    assign advance       = in_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign f_x0   = in_data_reg[0 +: R];
    assign f_y0   = in_data_reg[R +: R];
    assign f_x1   = in_data_reg[2 * R +: R];
    assign f_y1   = in_data_reg[3 * R +: R];
    assign f_fw   = in_data_reg[4 * R +: SIZE_W];
    assign f_fh   = in_data_reg[4 * R + SIZE_W +: SIZE_W];
    assign f_rate = in_data_reg[4 * R + 2 * SIZE_W +: RATE_W];
    assign f_iw   = in_data_reg[4 * R + 2 * SIZE_W + RATE_W +: SIZE_W];
    assign f_ih   = in_data_reg[4 * R + 3 * SIZE_W + RATE_W +: SIZE_W];

    bbws_rect #(
        .RAW_COORD_BITS (RAW_COORD_BITS)
    ) u_rect (
        .raw_x_start      (f_x0),
        .raw_y_start      (f_y0),
        .raw_x_end        (f_x1),
        .raw_y_end        (f_y1),
        .frame_width      (f_fw),
        .frame_height     (f_fh),
        .prev_left        (prev_l_reg),
        .prev_right       (prev_r_reg),
        .held_left        (held_l_reg),
        .held_right       (held_r_reg),
        .jitter_threshold (thr_reg),
        .sel_left         (sel_l),
        .sel_right        (sel_r),
        .act_x            (act_x),
        .act_y            (act_y),
        .act_w            (act_w),
        .act_h            (act_h),
        .clamped          (clamped)
    );

    assign act_rect = {act_x, act_y, act_w, act_h};

    always_comb begin
        if (f_fw == '0) begin
            skip = SKIP_FRAME_W;
        end else if (f_fh == '0) begin
            skip = SKIP_FRAME_H;
        end else if (f_rate == '0) begin
            skip = SKIP_RATE;
        end else if (f_iw == '0) begin
            skip = SKIP_INPUT_W;
        end else if (f_ih == '0) begin
            skip = SKIP_INPUT_H;
        end else begin
            skip = SKIP_NONE;
        end
    end

    always_comb begin
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            match[i] = (hist_reg[i] == act_rect);
        end
        match_ext = MXW'(match);
        // an empty rectangle counts nothing
        if (act_w != '0 && act_h != '0) begin
            cnt_ext = CXW'($countones(match)) + CXW'(1);
        end else begin
            cnt_ext   = '0;
            match_ext = '0;
        end
        same = (prev_size_reg == {f_fw, f_fh}) && (prev_rect_reg == act_rect);
        same_hist_next = {same_hist_reg[1:0], same};
        stable = (same_hist_next == SAME_STABLE) || (cnt_ext >= CXW'(MATCH_STABLE));
        report = stable && (reported_reg != act_rect);
    end

    // next state for one processed word
    always_comb begin
        prev_l_next    = prev_l_reg;
        prev_r_next    = prev_r_reg;
        held_l_next    = held_l_reg;
        held_r_next    = held_r_reg;
        reported_next  = reported_reg;
        res_next       = '0;
        user_next      = '0;
        user_next.skip_code = skip;
        if (skip != SKIP_NONE) begin
            prev_size_next = '1;
            prev_rect_next = '1;
        end else begin
            prev_l_next    = f_x0;
            prev_r_next    = f_x1;
            held_l_next    = sel_l;
            held_r_next    = sel_r;
            prev_size_next = {f_fw, f_fh};
            prev_rect_next = act_rect;
            if (report) begin
                reported_next = act_rect;
            end
            user_next.report_change = report;
            res_next.active_x    = OUT_X_W'(act_x);
            res_next.active_y    = OUT_Y_W'(act_y);
            res_next.active_w    = act_w;
            res_next.active_h    = act_h;
            res_next.match_count = cnt_ext[CNT_OUT_W-1:0];
            res_next.match_mask  = match_ext[MASK_OUT_W-1:0];
            res_next.was_clamped = clamped;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            thr_reg       <= THR_RESET;
            prev_l_reg    <= '1;
            prev_r_reg    <= '1;
            held_l_reg    <= '1;
            held_r_reg    <= '1;
            prev_size_reg <= '1;
            prev_rect_reg <= '1;
            reported_reg  <= '1;
            same_hist_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                hist_reg[i] <= '1;
            end
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (advance) begin
                prev_l_reg    <= prev_l_next;
                prev_r_reg    <= prev_r_next;
                held_l_reg    <= held_l_next;
                held_r_reg    <= held_r_next;
                prev_size_reg <= prev_size_next;
                prev_rect_reg <= prev_rect_next;
                reported_reg  <= reported_next;
                if (skip != SKIP_NONE) begin
                    same_hist_reg <= '0;
                end else begin
                    same_hist_reg <= same_hist_next;
                    hist_reg[0]   <= act_rect;
                    for (int i = 1; i < HISTORY_DEPTH; i++) begin
                        hist_reg[i] <= hist_reg[i-1];
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_axis_tdata;
        end
        if (advance) begin
            res_reg  <= res_next;
            user_reg <= user_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(res_reg);
    assign m_axis_tuser  = user_reg;

endmodule

`default_nettype wire

// File: rtl/bbws_rect.sv
// horizontal jitter hold, active rectangle build and oversize clamp
`timescale 1ns / 1ps
`default_nettype none

module bbws_rect import bbws_pkg::*; #(
    parameter int RAW_COORD_BITS = BBWS_RAW_COORD_BITS
) (
    input  wire logic [RAW_COORD_BITS-1:0] raw_x_start,
    input  wire logic [RAW_COORD_BITS-1:0] raw_y_start,
    input  wire logic [RAW_COORD_BITS-1:0] raw_x_end,
    input  wire logic [RAW_COORD_BITS-1:0] raw_y_end,
    input  wire logic [SIZE_W-1:0]         frame_width,
    input  wire logic [SIZE_W-1:0]         frame_height,
    input  wire logic [RAW_COORD_BITS-1:0] prev_left,
    input  wire logic [RAW_COORD_BITS-1:0] prev_right,
    input  wire logic [RAW_COORD_BITS-1:0] held_left,
    input  wire logic [RAW_COORD_BITS-1:0] held_right,
    input  wire logic [THR_W-1:0]          jitter_threshold,
    output logic      [RAW_COORD_BITS-1:0] sel_left,
    output logic      [RAW_COORD_BITS-1:0] sel_right,
    output logic      [RAW_COORD_BITS:0]   act_x,
    output logic      [RAW_COORD_BITS-1:0] act_y,
    output logic      [SIZE_W-1:0]         act_w,
    output logic      [SIZE_W-1:0]         act_h,
    output logic                           clamped
);

    localparam int R    = RAW_COORD_BITS;
    localparam int SUMW = (R + 1 > THR_W) ? R + 1 : THR_W;
    localparam int CW   = (R + 2 > SIZE_W) ? R + 2 : SIZE_W;

    logic [R-1:0]   diff_l;
    logic [R-1:0]   diff_r;
    logic [R:0]     diff_sum;
    logic           keep;
    logic           inverted;
    logic [R+1:0]   w_raw;
    logic [R:0]     h_raw;
    logic [CW-1:0]  w_cmp;
    logic [CW-1:0]  h_cmp;

    always_comb begin
        diff_l   = (raw_x_start >= prev_left)  ? raw_x_start - prev_left  : prev_left - raw_x_start;
        diff_r   = (raw_x_end   >= prev_right) ? raw_x_end - prev_right   : prev_right - raw_x_end;
        diff_sum = {1'b0, diff_l} + {1'b0, diff_r};
        keep     = SUMW'(diff_sum) <= SUMW'(jitter_threshold);

        sel_left  = keep ? held_left  : raw_x_start;
        sel_right = keep ? held_right : raw_x_end;

        inverted = (sel_left > sel_right) || (raw_y_start > raw_y_end);
        w_raw    = (sel_right > sel_left) ?
                   {(R + 1)'(sel_right - sel_left) + (R + 1)'(1), 1'b0} : '0;
        h_raw    = (raw_y_end > raw_y_start) ?
                   (R + 1)'(raw_y_end - raw_y_start) + (R + 1)'(1) : '0;
        if (inverted) begin
            w_raw = '0;
            h_raw = '0;
        end
        w_cmp   = CW'(w_raw);
        h_cmp   = CW'(h_raw);
        clamped = (w_cmp > CW'(frame_width)) || (h_cmp > CW'(frame_height));

        if (clamped) begin
            act_x = '0;
            act_y = '0;
            act_w = frame_width;
            act_h = frame_height;
        end else if (inverted) begin
            act_x = '0;
            act_y = '0;
            act_w = '0;
            act_h = '0;
        end else begin
            // in range here, so the low bits carry the whole value
            act_x = {sel_left, 1'b0};
            act_y = raw_y_start;
            act_w = w_cmp[SIZE_W-1:0];
            act_h = h_cmp[SIZE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bbws_checker.sv
// port-level checks on the stabilizer result stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "black_bar_window_stabilizer_unit_macros.svh"

module bbws_checker import bbws_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] m_axis_tuser
);

    result_t      res;
    result_user_t usr;

    assign res = result_t'(m_axis_tdata[RESULT_W-1:0]);
    assign usr = result_user_t'(m_axis_tuser);

    // a stalled word stays offered
    `BBWS_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result word dropped while stalled")

    // a skipped frame carries nothing but its code
    `BBWS_ASSERT_IMPLY(a_skip_empty, aclk, aresetn, m_axis_tvalid && usr.skip_code != SKIP_NONE, m_axis_tdata == '0 && !usr.report_change, "skipped frame with nonzero result")

    // a clamped rectangle is the full frame at the origin
    `BBWS_ASSERT_IMPLY(a_clamp_origin, aclk, aresetn, m_axis_tvalid && res.was_clamped, res.active_x == '0 && res.active_y == '0, "clamped rectangle not at origin")

    // an empty rectangle is never matched against history
    `BBWS_ASSERT_IMPLY(a_empty_nomatch, aclk, aresetn, m_axis_tvalid && (res.active_w == '0 || res.active_h == '0), res.match_count == '0 && res.match_mask == '0, "empty rectangle shows matches")

endmodule

bind black_bar_window_stabilizer_unit bbws_checker u_bbws_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
